FILE: rtl/psm_pkg.sv
`default_nettype none
package psm_pkg;

  localparam int StackDepthDef = 1024;
  localparam int ProgDepthDef  = 1024;
  localparam int MaxLevelDef   = 15;

  typedef enum logic [3:0] {
    OP_LIT = 4'd0, OP_OPR = 4'd1, OP_LOD = 4'd2, OP_STO = 4'd3, OP_CAL = 4'd4,
    OP_INT = 4'd5, OP_JMP = 4'd6, OP_JPC = 4'd7, OP_END = 4'd8
  } op_code_t;

  localparam logic [31:0] OPR_RET = 32'd0;
  localparam logic [31:0] OPR_NEG = 32'd1;
  localparam logic [31:0] OPR_ADD = 32'd2;
  localparam logic [31:0] OPR_SUB = 32'd3;
  localparam logic [31:0] OPR_MUL = 32'd4;
  localparam logic [31:0] OPR_DIV = 32'd5;
  localparam logic [31:0] OPR_MOD = 32'd6;
  localparam logic [31:0] OPR_EQL = 32'd8;
  localparam logic [31:0] OPR_NEQ = 32'd9;
  localparam logic [31:0] OPR_LSS = 32'd10;
  localparam logic [31:0] OPR_GEQ = 32'd11;
  localparam logic [31:0] OPR_GTR = 32'd12;
  localparam logic [31:0] OPR_LEQ = 32'd13;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
  localparam logic [2:0] ERR_RANGE     = 3'd3;
  localparam logic [2:0] ERR_DIVZERO   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WALK_RD, ST_WALK, ST_RD_A, ST_RD_B, ST_EXEC, ST_DIV, ST_WR2, ST_WR3,
    ST_TOP_RD, ST_OUT
  } state_t;

  typedef struct packed {
    logic [3:0]         op;
    logic [3:0]         level;
    logic signed [31:0] arg;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         next_pc;
    logic signed [31:0] top_value;
    logic               store_valid;
    logic signed [31:0] store_value;
    logic               halted;
    logic [2:0]         error_code;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/pcode_stack_machine_step.sv
// PL/0 p-code step engine. Each input beat carries one instruction fetched at the
// program counter reported by the previous result beat, and yields exactly one
// result beat. The stack lives in a synchronous RAM with one read and one write
// port, so an instruction makes its memory accesses one at a time. The next
// instruction is taken only after the result beat of the last one is registered.
// A call writes its three frame words one after another, lod, sto and cal read one
// static link per level walked, and a divide or remainder by a nonzero word runs
// on a one-bit-per-cycle restoring divider. A stalled result beat does not hold the
// input off: the next instruction is taken and runs, and its result waits until
// the stalled beat is taken. Stack words 1 to 3 read as zero until first written.
// Once halted, a beat goes straight to the top read and yields its result.
`default_nettype none
module pcode_stack_machine_step
  import psm_pkg::*;
#(
  parameter int STACK_DEPTH = StackDepthDef,
  parameter int PROG_DEPTH  = ProgDepthDef,
  parameter int MAX_LEVEL   = MaxLevelDef
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(PROG_DEPTH);
  localparam logic signed [33:0] SDEP = 34'(STACK_DEPTH);
  localparam logic signed [33:0] PDEP = 34'(PROG_DEPTH);

  logic [31:0] mem [STACK_DEPTH];
  logic [2:0]  init_ok_r, init_ok_nxt;

  state_t state_r, state_nxt;
  in_item_t ins_r, ins_nxt;
  logic [PW-1:0] pc_r, pc_nxt;
  logic [AW-1:0] b_r, b_nxt, t_r, t_nxt;
  logic halt_r, halt_nxt;
  logic [AW-1:0] b1_r, b1_nxt;
  logic [3:0] lcnt_r, lcnt_nxt;
  logic [31:0] x_r, x_nxt, y_r, y_nxt;
  logic [2:0] err_r, err_nxt;
  logic sv_r, sv_nxt;
  logic [31:0] svv_r, svv_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  logic [5:0] dcnt_r, dcnt_nxt;
  logic [31:0] quo_r, quo_nxt, rem_r, rem_nxt;

  logic        rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_data, rd_raw_r, rd_data;
  logic [AW-1:0] rd_addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw_r  <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_comb begin
    rd_data = rd_raw_r;
    if (rd_addr_r == AW'(1) && !init_ok_r[0]) rd_data = '0;
    if (rd_addr_r == AW'(2) && !init_ok_r[1]) rd_data = '0;
    if (rd_addr_r == AW'(3) && !init_ok_r[2]) rd_data = '0;
  end

  logic signed [33:0] t_s, b_s, sa;
  logic signed [33:0] w_s, rd_s;
  logic signed [33:0] addr_s, tsa;
  logic [PW-1:0] next_seq;
  logic [31:0] sy_abs, dq, dr;
  logic [32:0] rem_try;
  logic lev_bad;

  always_comb begin
    t_s = 34'(t_r);
    b_s = 34'(b_r);
    sa = 34'(ins_r.arg);
    rd_s = 34'($signed(rd_data));
    w_s = rd_s;
    next_seq = (34'(pc_r) + 34'sd1 >= PDEP) ? '0 : PW'(pc_r + PW'(1));
    addr_s = 34'(b1_r) + sa + 34'sd2;
    tsa = t_s + sa;
    lev_bad = 32'(ins_r.level) > 32'(MAX_LEVEL);
    sy_abs = y_r[31] ? 32'(-y_r) : y_r;
    rem_try = {rem_r, quo_r[31]} - {1'b0, sy_abs};
    dq = (x_r[31] ^ y_r[31]) ? 32'(-quo_r) : quo_r;
    dr = x_r[31] ? 32'(-rem_r) : rem_r;
  end

  always_comb begin
    state_nxt = state_r;
    ins_nxt = ins_r;
    pc_nxt = pc_r;
    b_nxt = b_r;
    t_nxt = t_r;
    halt_nxt = halt_r;
    b1_nxt = b1_r;
    lcnt_nxt = lcnt_r;
    x_nxt = x_r;
    y_nxt = y_r;
    err_nxt = err_r;
    sv_nxt = sv_r;
    svv_nxt = svv_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt = out_r;
    dcnt_nxt = dcnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    init_ok_nxt = init_ok_r;
    rd_en = 1'b0;
    rd_addr = t_r;
    wr_en = 1'b0;
    wr_addr = t_r;
    wr_data = '0;
    in_stall = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ins_nxt = in_data;
          err_nxt = ERR_NONE;
          sv_nxt = 1'b0;
          svv_nxt = '0;
          b1_nxt = b_r;
          lcnt_nxt = in_data.level;
          if (halt_r) begin
            state_nxt = ST_TOP_RD;
          end else begin
            state_nxt = ST_WALK_RD;
          end
        end
      end
      ST_WALK_RD: begin
        if (lev_bad || lcnt_r == '0 ||
            !(ins_r.op == OP_LOD || ins_r.op == OP_STO || ins_r.op == OP_CAL)) begin
          state_nxt = ST_RD_A;
        end else begin
          rd_en = 1'b1;
          rd_addr = b1_r;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        lcnt_nxt = lcnt_r - 4'd1;
        if (w_s < 0 || w_s >= SDEP) begin
          err_nxt = ERR_RANGE;
          lcnt_nxt = '0;
          state_nxt = ST_RD_A;
        end else begin
          b1_nxt = AW'(rd_data);
          state_nxt = ST_WALK_RD;
        end
      end
      ST_RD_A: begin
        // First operand read: return frame word, top, or load source.
        state_nxt = ST_RD_B;
        if (ins_r.op == OP_OPR && sa == 0) begin
          rd_en = (b_s + 2 < SDEP);
          rd_addr = AW'(b_s + 2);
        end else if (ins_r.op == OP_LOD) begin
          rd_en = 1'b1;
          rd_addr = AW'(addr_s);
        end else begin
          rd_en = 1'b1;
          rd_addr = t_r;
        end
      end
      ST_RD_B: begin
        x_nxt = rd_data;
        state_nxt = ST_EXEC;
        if (ins_r.op == OP_OPR && sa == 0) begin
          rd_en = (b_s + 1 < SDEP);
          rd_addr = AW'(b_s + 1);
        end else begin
          rd_en = 1'b1;
          rd_addr = AW'(t_s - 1);
        end
      end
      ST_EXEC: begin
        state_nxt = ST_TOP_RD;
        pc_nxt = next_seq;
        unique case (ins_r.op)
          OP_LIT: begin
            if (t_s + 1 >= SDEP) err_nxt = ERR_OVERFLOW;
            else begin
              t_nxt = AW'(t_s + 1);
              wr_en = 1'b1;
              wr_addr = AW'(t_s + 1);
              wr_data = ins_r.arg;
            end
          end
          OP_OPR: begin
            if (sa == 34'(OPR_RET)) begin
              if (b_r == '0) err_nxt = ERR_UNDERFLOW;
              else if (b_s + 2 >= SDEP) err_nxt = ERR_RANGE;
              else if (34'($signed(x_r)) < 0 || 34'($signed(x_r)) >= PDEP ||
                       rd_s < 0 || rd_s >= SDEP) err_nxt = ERR_RANGE;
              else begin
                t_nxt = AW'(b_s - 1);
                pc_nxt = PW'(x_r);
                b_nxt = AW'(rd_data);
              end
            end else if (sa == 34'(OPR_NEG)) begin
              if (t_r == '0) err_nxt = ERR_UNDERFLOW;
              else begin
                wr_en = 1'b1;
                wr_addr = t_r;
                wr_data = 32'(-x_r);
              end
            end else if ((sa >= 2 && sa <= 6) || (sa >= 8 && sa <= 13)) begin
              if (t_s < 2) err_nxt = ERR_UNDERFLOW;
              else begin
                t_nxt = AW'(t_s - 1);
                wr_en = 1'b1;
                wr_addr = AW'(t_s - 1);
                x_nxt = rd_data;
                y_nxt = x_r;
                priority case (1'b1)
                  sa == 34'(OPR_ADD): wr_data = rd_data + x_r;
                  sa == 34'(OPR_SUB): wr_data = rd_data - x_r;
                  sa == 34'(OPR_MUL): wr_data = 32'(rd_data * x_r);
                  sa == 34'(OPR_EQL): wr_data = 32'(rd_data == x_r);
                  sa == 34'(OPR_NEQ): wr_data = 32'(rd_data != x_r);
                  sa == 34'(OPR_LSS): wr_data = 32'($signed(rd_data) < $signed(x_r));
                  sa == 34'(OPR_GEQ): wr_data = 32'($signed(rd_data) >= $signed(x_r));
                  sa == 34'(OPR_GTR): wr_data = 32'($signed(rd_data) > $signed(x_r));
                  sa == 34'(OPR_LEQ): wr_data = 32'($signed(rd_data) <= $signed(x_r));
                  default: begin
                    wr_en = 1'b0;
                    if (x_r == '0) begin
                      err_nxt = ERR_DIVZERO;
                      wr_en = 1'b1;
                      wr_data = '0;
                    end else begin
                      dcnt_nxt = 6'd32;
                      quo_nxt = rd_data[31] ? 32'(-rd_data) : rd_data;
                      rem_nxt = '0;
                      state_nxt = ST_DIV;
                    end
                  end
                endcase
              end
            end
          end
          OP_LOD: begin
            if (t_s + 1 >= SDEP) err_nxt = ERR_OVERFLOW;
            else if (err_r != ERR_NONE || lev_bad || addr_s < 0 || addr_s >= SDEP)
              err_nxt = ERR_RANGE;
            else begin
              t_nxt = AW'(t_s + 1);
              wr_en = 1'b1;
              wr_addr = AW'(t_s + 1);
              wr_data = x_r;
            end
          end
          OP_STO: begin
            if (t_r == '0) err_nxt = ERR_UNDERFLOW;
            else if (err_r != ERR_NONE || lev_bad || addr_s < 0 || addr_s >= SDEP)
              err_nxt = ERR_RANGE;
            else begin
              sv_nxt = 1'b1;
              svv_nxt = x_r;
              wr_en = 1'b1;
              wr_addr = AW'(addr_s);
              wr_data = x_r;
              t_nxt = AW'(t_s - 1);
            end
          end
          OP_CAL: begin
            if (t_s + 3 >= SDEP) err_nxt = ERR_OVERFLOW;
            else if (err_r != ERR_NONE || lev_bad || sa < 0 || sa >= PDEP)
              err_nxt = ERR_RANGE;
            else begin
              wr_en = 1'b1;
              wr_addr = AW'(t_s + 1);
              wr_data = 32'(b1_r);
              state_nxt = ST_WR2;
            end
          end
          OP_INT: begin
            if (tsa >= SDEP) err_nxt = ERR_OVERFLOW;
            else if (tsa < 0) err_nxt = ERR_UNDERFLOW;
            else t_nxt = AW'(tsa);
          end
          OP_JMP: begin
            if (sa < 0 || sa >= PDEP) err_nxt = ERR_RANGE;
            else pc_nxt = PW'(sa);
          end
          OP_JPC: begin
            if (t_r == '0) err_nxt = ERR_UNDERFLOW;
            else if (sa < 0 || sa >= PDEP) err_nxt = ERR_RANGE;
            else begin
              if (x_r == '0) pc_nxt = PW'(sa);
              t_nxt = AW'(t_s - 1);
            end
          end
          default: begin
            err_nxt = ERR_NONE;
          end
        endcase
        if (ins_r.op == OP_LOD || ins_r.op == OP_STO || ins_r.op == OP_CAL) begin
          if (err_nxt == ERR_NONE && err_r != ERR_NONE) err_nxt = err_r;
        end
        if (ins_r.op != OP_LOD && ins_r.op != OP_STO && ins_r.op != OP_CAL &&
            err_nxt == err_r && err_r == ERR_RANGE) begin
          err_nxt = ERR_NONE;
        end
      end
      ST_DIV: begin
        if (dcnt_r != '0) begin
          dcnt_nxt = dcnt_r - 6'd1;
          if (!rem_try[32]) begin
            rem_nxt = rem_try[31:0];
            quo_nxt = {quo_r[30:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[30:0], quo_r[31]};
            quo_nxt = {quo_r[30:0], 1'b0};
          end
        end else begin
          wr_en = 1'b1;
          wr_addr = t_r;
          wr_data = (ins_r.arg == OPR_DIV) ? dq : dr;
          state_nxt = ST_TOP_RD;
        end
      end
      ST_WR2: begin
        wr_en = 1'b1;
        wr_addr = AW'(t_s + 2);
        wr_data = 32'(b_r);
        state_nxt = ST_WR3;
      end
      ST_WR3: begin
        wr_en = 1'b1;
        wr_addr = AW'(t_s + 3);
        wr_data = 32'(pc_r);
        b_nxt = AW'(t_s + 1);
        pc_nxt = PW'(sa);
        state_nxt = ST_TOP_RD;
      end
      ST_TOP_RD: begin
        if (pc_r == '0) halt_nxt = 1'b1;
        rd_en = 1'b1;
        rd_addr = t_r;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt.next_pc = 10'(pc_r);
          out_nxt.top_value = rd_data;
          out_nxt.store_valid = sv_r;
          out_nxt.store_value = svv_r;
          out_nxt.halted = halt_r;
          out_nxt.error_code = err_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (wr_en) begin
      if (wr_addr == AW'(1)) init_ok_nxt[0] = 1'b1;
      if (wr_addr == AW'(2)) init_ok_nxt[1] = 1'b1;
      if (wr_addr == AW'(3)) init_ok_nxt[2] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r <= '0;
      b_r <= AW'(1);
      t_r <= '0;
      halt_r <= 1'b0;
      out_valid_r <= 1'b0;
      init_ok_r <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt;
      b_r <= b_nxt;
      t_r <= t_nxt;
      halt_r <= halt_nxt;
      out_valid_r <= out_valid_nxt;
      init_ok_r <= init_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r <= ins_nxt;
    b1_r <= b1_nxt;
    lcnt_r <= lcnt_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    err_r <= err_nxt;
    sv_r <= sv_nxt;
    svv_r <= svv_nxt;
    out_r <= out_nxt;
    dcnt_r <= dcnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef SYNTH
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall)
    else $error("input taken while busy");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(halt_r) && $past(rst_n) |-> halt_r)
    else $error("halt flag cleared");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat dropped");
`endif

endmodule
`default_nettype wire
